[rtl/snf_pkg.sv]
`timescale 1ns / 1ps

package snf_pkg;

  localparam int unsigned DIM_W    = 16;
  localparam int unsigned CURX_W   = 17;
  localparam int unsigned AREA_W   = 2 * DIM_W;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_BIN_WIDTH  = 1'b0,
    REG_BIN_HEIGHT = 1'b1
  } reg_index_t;

  // placement result codes
  typedef enum logic [1:0] {
    ST_FIT    = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_AREA   = 2'd3
  } status_t;

  // shelf cursor state
  typedef struct packed {
    logic [CURX_W-1:0] cursor_x;
    logic [DIM_W-1:0]  cursor_y;
    logic [DIM_W-1:0]  shelf_height;
  } shelf_state_t;

  // one placement outcome
  typedef struct packed {
    status_t           status;
    logic              rotated;
  } place_result_t;

endpackage

[rtl/shelf_next_fit_placer.sv]
`timescale 1ns / 1ps
// the input transaction is registered in stage one and then in the result register on the master side
// throughput: one rectangle per cycle while m_axis_tready is high; the cursor update is combinational logic
// stage one registers the rectangle and its area product, stage two places it
// and holds the result until taken
// reset (synchronous, active high) zeroes box size, cursor and shelf height

module shelf_next_fit_placer (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // rectangle in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [snf_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // rect_width[15:0],
                                                        // rect_height[31:16]
  // placement out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [snf_pkg::OUT_DATA_W-1:0] m_axis_tdata   // status[1:0], rotated[2],
                                                        // cursor_x_out[19:3],
                                                        // cursor_y_out[35:20],
                                                        // zero[39:36]
);
  import snf_pkg::*;

  logic [DIM_W-1:0]  bin_width;
  logic [DIM_W-1:0]  bin_height;
  logic [AREA_W-1:0] box_area;

  logic              s1_valid;
  logic [DIM_W-1:0]  s1_width;
  logic [DIM_W-1:0]  s1_height;
  logic [AREA_W-1:0] s1_area;
  logic              s1_fire;
  logic              in_fire;

  shelf_state_t      state;
  shelf_state_t      state_next;
  place_result_t     step_res;

  logic              out_valid;
  place_result_t     out_res;
  logic [CURX_W-1:0] out_cx;
  logic [DIM_W-1:0]  out_cy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width  <= '0;
      bin_height <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_BIN_WIDTH:  bin_width  <= cfg_data;
        REG_BIN_HEIGHT: bin_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // box area is registered and follows the registers in the next cycle
  always_ff @(posedge clk) begin
    box_area <= AREA_W'(bin_width) * AREA_W'(bin_height);
  end

  // handshake
  assign s1_fire       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // stage one: capture rectangle and its area
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_width  <= s_axis_tdata[15:0];
      s1_height <= s_axis_tdata[31:16];
      s1_area   <= AREA_W'(s_axis_tdata[15:0]) * AREA_W'(s_axis_tdata[31:16]);
    end
  end

  // stage two: placement step
  snf_step u_step (
    .cur         (state),
    .bin_width   (bin_width),
    .bin_height  (bin_height),
    .rect_width  (s1_width),
    .rect_height (s1_height),
    .area_over   (s1_area > box_area),
    .nxt         (state_next),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= step_res;
      out_cx  <= state_next.cursor_x;
      out_cy  <= state_next.cursor_y;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_cy, out_cx, out_res.rotated, out_res.status};

  // rejected rectangles never mark a rotation
  a_rot_only_on_fit: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && step_res.status != ST_FIT) |-> !step_res.rotated)
    else $error("rotated set on a rejected rectangle");

  // area and full rejections leave the cursor alone
  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (step_res.status == ST_AREA || step_res.status == ST_FULL))
      |=> (state == $past(state)))
    else $error("cursor changed on an area or full rejection");

  // empty stage one always takes a new rectangle
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_axis_tready)
    else $error("input stalled with stage one empty");

  // state only moves together with a new result
  a_state_with_result: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> (state == $past(state)))
    else $error("cursor changed without a placement");

endmodule

[rtl/snf_step.sv]
`timescale 1ns / 1ps

module snf_step (
  input  snf_pkg::shelf_state_t  cur,
  input  logic [15:0]            bin_width,
  input  logic [15:0]            bin_height,
  input  logic [15:0]            rect_width,
  input  logic [15:0]            rect_height,
  input  logic                   area_over,
  output snf_pkg::shelf_state_t  nxt,
  output snf_pkg::place_result_t res
);
  import snf_pkg::*;

  logic              box_full;
  logic              advance;
  logic [DIM_W:0]    base_sum;
  logic [CURX_W-1:0] cx1;
  logic [DIM_W-1:0]  cy1;
  logic [DIM_W-1:0]  sh1;
  logic              height_fail;
  logic [DIM_W-1:0]  big;
  logic [DIM_W-1:0]  small_side;
  logic              upright_ok;
  logic [CURX_W:0]   cx_sum;
  logic              rot_shape;

  // shelf advance when the width overflows the current shelf
  assign box_full = cur.cursor_y >= bin_height;
  assign advance  = ({1'b0, cur.cursor_x} + {2'b00, rect_width}) >
                    {2'b00, bin_width};
  assign base_sum = {1'b0, cur.cursor_y} + {1'b0, cur.shelf_height};

  assign cx1 = advance ? '0 : cur.cursor_x;
  assign cy1 = advance ? (base_sum[DIM_W] ? {DIM_W{1'b1}} : base_sum[DIM_W-1:0])
                       : cur.cursor_y;
  assign sh1 = advance ? '0 : cur.shelf_height;

  // height check on the (possibly new) shelf
  assign height_fail = ({1'b0, cy1} + {1'b0, rect_height}) > {1'b0, bin_height};

  // orientation choice
  assign big        = (rect_width > rect_height) ? rect_width : rect_height;
  assign small_side = (rect_width > rect_height) ? rect_height : rect_width;
  assign rot_shape  = rect_height < rect_width;
  assign upright_ok = (({1'b0, cy1} + {1'b0, big}) <= {1'b0, bin_height}) &&
                      (({1'b0, cx1} + {2'b00, big}) <= {2'b00, bin_width});

  always_comb begin
    nxt         = cur;
    res.status  = ST_FIT;
    res.rotated = 1'b0;
    cx_sum      = '0;
    if (area_over) begin
      res.status = ST_AREA;
    end else if (box_full) begin
      res.status = ST_FULL;
    end else begin
      nxt.cursor_x     = cx1;
      nxt.cursor_y     = cy1;
      nxt.shelf_height = sh1;
      if (height_fail) begin
        res.status = ST_NOFIT;
      end else if (sh1 != '0) begin
        if (upright_ok) begin
          // stand the rectangle up
          if (big > sh1) begin
            nxt.shelf_height = big;
          end
          cx_sum      = {1'b0, cx1} + {2'b00, small_side};
          res.rotated = rot_shape;
        end else begin
          // keep the given orientation
          if (rect_height > sh1) begin
            nxt.shelf_height = rect_height;
          end
          cx_sum = {1'b0, cx1} + {2'b00, rect_width};
        end
        nxt.cursor_x = cx_sum[CURX_W-1:0];
      end else begin
        // first on the shelf lies flat
        nxt.shelf_height = small_side;
        cx_sum           = {1'b0, cx1} + {2'b00, big};
        nxt.cursor_x     = cx_sum[CURX_W-1:0];
        res.rotated      = rot_shape;
      end
    end
  end

endmodule
